FILE: src/stepper_step_generator_with_targets_defines.svh
// Assertion macros shared by the stepper step generator RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef STEPPER_STEP_GENERATOR_WITH_TARGETS_DEFINES_SVH
`define STEPPER_STEP_GENERATOR_WITH_TARGETS_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define SSGT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define SSGT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/ssgt_pkg.sv
// Shared widths, request and register codes, and types of the step generator.
// No dependencies; used by the interfaces, ssgt_eval and the top level.
package ssgt_pkg;

	localparam int POS_W      = 32;
	localparam int BUDGET_W   = 32;
	localparam int TOL_W      = 16;
	localparam int BOUND_W    = 34;
	localparam int REQ_W      = 3;
	localparam int REASON_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_TICK        = 3'd0;
	localparam logic [REQ_W-1:0] REQ_START       = 3'd1;
	localparam logic [REQ_W-1:0] REQ_STOP        = 3'd2;
	localparam logic [REQ_W-1:0] REQ_STEP_TARGET = 3'd3;
	localparam logic [REQ_W-1:0] REQ_ENC_TARGET  = 3'd4;
	localparam logic [REQ_W-1:0] REQ_CLEAR       = 3'd5;

	// Stop reasons
	localparam logic [REASON_W-1:0] WHY_COMMANDED   = 2'd0;
	localparam logic [REASON_W-1:0] WHY_STEPS_DONE  = 2'd1;
	localparam logic [REASON_W-1:0] WHY_POS_REACHED = 2'd2;
	localparam logic [REASON_W-1:0] WHY_EXCEEDED    = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_POS_TOL     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKLASH    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ENC_PRESENT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DIR_LEVEL   = 2'd3;

	// Configuration reset values
	localparam logic [TOL_W-1:0] POS_TOL_RST     = 16'd10;
	localparam logic [TOL_W-1:0] BACKLASH_RST    = 16'd100;
	localparam logic             ENC_PRESENT_RST = 1'b1;
	localparam logic             DIR_LEVEL_RST   = 1'b0;

	typedef struct packed {
		logic [REQ_W-1:0]    req_type;
		logic [BUDGET_W-1:0] step_budget;
		logic [POS_W-1:0]    encoder_goal;
		logic [POS_W-1:0]    encoder_position;
	} item_t;

	typedef struct packed {
		logic [TOL_W-1:0] position_tolerance;
		logic [TOL_W-1:0] backlash_tolerance;
		logic             encoder_present;
		logic             direction_level;
	} cfg_t;

	typedef struct packed {
		logic                step_state;
		logic                run_flag;
		logic [BUDGET_W-1:0] steps_left;
		logic                step_mode_armed;
		logic                encoder_mode_armed;
		logic [POS_W-1:0]    goal_position;
		logic                goal_direction_up;
		logic [BOUND_W-1:0]  failsafe_bound;
	} state_t;

	typedef struct packed {
		logic                step_level;
		logic                enable_n;
		logic                direction_out;
		logic                is_running;
		logic                stop_event;
		logic [REASON_W-1:0] stop_reason;
	} result_t;

	// Sign-extend an encoder count to the wide difference width
	function automatic logic [BOUND_W-1:0] sext_pos(input logic [POS_W-1:0] v);
		return {{(BOUND_W-POS_W){v[POS_W-1]}}, v};
	endfunction

	// Zero-extend a tolerance to the wide difference width
	function automatic logic [BOUND_W-1:0] zext_tol(input logic [TOL_W-1:0] v);
		return {{(BOUND_W-TOL_W){1'b0}}, v};
	endfunction

endpackage

FILE: src/ssgt_req_if.sv
// Request channel of the step generator: valid/ready plus one request.
// Depends on ssgt_pkg for field widths.
interface ssgt_req_if;
	logic                             valid;
	logic                             ready;
	logic [ssgt_pkg::REQ_W-1:0]       req_type;
	logic [ssgt_pkg::BUDGET_W-1:0]    step_budget;
	logic signed [ssgt_pkg::POS_W-1:0] encoder_goal;
	logic signed [ssgt_pkg::POS_W-1:0] encoder_position;

	modport source (output valid, req_type, step_budget, encoder_goal, encoder_position,
		input ready);
	modport sink (input valid, req_type, step_budget, encoder_goal, encoder_position,
		output ready);
endinterface

FILE: src/ssgt_res_if.sv
// Result channel of the step generator: valid/ready plus pin levels and stop status.
// Depends on ssgt_pkg for field widths.
interface ssgt_res_if;
	logic                          valid;
	logic                          ready;
	logic                          step_level;
	logic                          enable_n;
	logic                          direction_out;
	logic                          is_running;
	logic                          stop_event;
	logic [ssgt_pkg::REASON_W-1:0] stop_reason;

	modport source (output valid, step_level, enable_n, direction_out, is_running,
		stop_event, stop_reason, input ready);
	modport sink (input valid, step_level, enable_n, direction_out, is_running,
		stop_event, stop_reason, output ready);
endinterface

FILE: src/ssgt_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Depends on ssgt_pkg for field widths.
interface ssgt_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [ssgt_pkg::CFG_IDX_W-1:0]  index;
	logic [ssgt_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: src/ssgt_eval.sv
// Next-state and result logic for one request of the step generator.
// Purely combinational; depends on ssgt_pkg types and helpers.
module ssgt_eval (
	input  ssgt_pkg::state_t  st,
	input  ssgt_pkg::item_t   item,
	input  ssgt_pkg::cfg_t    cfg,
	output ssgt_pkg::state_t  st_nxt,
	output ssgt_pkg::result_t res
);

	logic signed [ssgt_pkg::BOUND_W-1:0] cur_w;
	logic signed [ssgt_pkg::BOUND_W-1:0] goal_in_w;
	logic signed [ssgt_pkg::BOUND_W-1:0] goal_st_w;
	logic signed [ssgt_pkg::BOUND_W-1:0] bound_w;
	logic signed [ssgt_pkg::BOUND_W-1:0] tol_w;
	logic signed [ssgt_pkg::BOUND_W-1:0] bl_w;
	logic signed [ssgt_pkg::BOUND_W-1:0] edge_diff;
	logic signed [ssgt_pkg::BOUND_W-1:0] edge_abs;
	logic signed [ssgt_pkg::BOUND_W-1:0] arm_diff;
	logic signed [ssgt_pkg::BOUND_W-1:0] arm_abs;
	logic                                edge_near;
	logic                                edge_hit;
	logic                                arm_far;
	logic [ssgt_pkg::BUDGET_W-1:0]       steps_dec;
	logic                                new_step;
	logic                                do_halt;
	logic [ssgt_pkg::REASON_W-1:0]       why;

	// Wide position arithmetic, never wraps
	always_comb begin
		cur_w     = $signed(ssgt_pkg::sext_pos(item.encoder_position));
		goal_in_w = $signed(ssgt_pkg::sext_pos(item.encoder_goal));
		goal_st_w = $signed(ssgt_pkg::sext_pos(st.goal_position));
		bound_w   = $signed(st.failsafe_bound);
		tol_w     = $signed(ssgt_pkg::zext_tol(cfg.position_tolerance));
		bl_w      = $signed(ssgt_pkg::zext_tol(cfg.backlash_tolerance));

		edge_diff = cur_w - goal_st_w;
		edge_abs  = edge_diff[ssgt_pkg::BOUND_W-1] ? -edge_diff : edge_diff;
		edge_near = edge_abs < tol_w;
		if (st.goal_direction_up) begin
			edge_hit = edge_near || (cur_w >= goal_st_w) || (cur_w < bound_w);
		end else begin
			edge_hit = edge_near || (cur_w <= goal_st_w) || (cur_w > bound_w);
		end

		arm_diff = goal_in_w - cur_w;
		arm_abs  = arm_diff[ssgt_pkg::BOUND_W-1] ? -arm_diff : arm_diff;
		arm_far  = arm_abs > tol_w;

		steps_dec = (st.steps_left != '0) ? st.steps_left - 1'b1 : st.steps_left;
	end

	// Request decode and state update
	always_comb begin
		st_nxt   = st;
		new_step = ~st.step_state;
		do_halt  = 1'b0;
		why      = ssgt_pkg::WHY_COMMANDED;

		unique case (item.req_type)
			ssgt_pkg::REQ_TICK: begin
				if (st.run_flag) begin
					st_nxt.step_state = new_step;
					// falling edge: check the armed target
					if (!new_step) begin
						if (st.step_mode_armed) begin
							st_nxt.steps_left = steps_dec;
							if (steps_dec == '0) begin
								do_halt = 1'b1;
								why     = ssgt_pkg::WHY_STEPS_DONE;
							end
						end else if (st.encoder_mode_armed && cfg.encoder_present) begin
							if (edge_hit) begin
								do_halt = 1'b1;
								why     = edge_near ? ssgt_pkg::WHY_POS_REACHED
									: ssgt_pkg::WHY_EXCEEDED;
							end
						end
					end
				end
			end
			ssgt_pkg::REQ_START: begin
				st_nxt.run_flag = 1'b1;
			end
			ssgt_pkg::REQ_STOP: begin
				do_halt = 1'b1;
				why     = ssgt_pkg::WHY_COMMANDED;
			end
			ssgt_pkg::REQ_STEP_TARGET: begin
				st_nxt.steps_left         = item.step_budget;
				st_nxt.step_mode_armed    = (item.step_budget != '0);
				st_nxt.encoder_mode_armed = 1'b0;
			end
			ssgt_pkg::REQ_ENC_TARGET: begin
				if (cfg.encoder_present) begin
					st_nxt.goal_position   = item.encoder_goal;
					st_nxt.step_mode_armed = 1'b0;
					if (arm_far) begin
						st_nxt.goal_direction_up  = (goal_in_w > cur_w);
						st_nxt.failsafe_bound     = (goal_in_w > cur_w) ? cur_w - bl_w
							: cur_w + bl_w;
						st_nxt.encoder_mode_armed = 1'b1;
					end else begin
						st_nxt.encoder_mode_armed = 1'b0;
						do_halt = 1'b1;
						why     = ssgt_pkg::WHY_POS_REACHED;
					end
				end
			end
			ssgt_pkg::REQ_CLEAR: begin
				st_nxt.step_mode_armed    = 1'b0;
				st_nxt.encoder_mode_armed = 1'b0;
			end
			default: begin
			end
		endcase

		// any stop drops run and both targets; step level is kept
		if (do_halt) begin
			st_nxt.run_flag           = 1'b0;
			st_nxt.step_mode_armed    = 1'b0;
			st_nxt.encoder_mode_armed = 1'b0;
		end

		res.step_level    = st_nxt.step_state;
		res.enable_n      = ~st_nxt.run_flag;
		res.direction_out = cfg.direction_level;
		res.is_running    = st_nxt.run_flag;
		res.stop_event    = do_halt;
		res.stop_reason   = do_halt ? why : ssgt_pkg::WHY_COMMANDED;
	end

endmodule

FILE: src/stepper_step_generator_with_targets.sv
// Top level of the stepper step pulse generator with step and encoder targets.
// Depends on ssgt_pkg, the three channel interfaces, ssgt_eval and the defines header.
//
// Usage:
//   req  - request channel: ticks from a half-period timer (each toggles the step
//          level while running) and commands: start, stop, arm a step budget, arm an
//          encoder goal, clear targets. Every request gives exactly one result.
//   res  - result channel: step pin, active-low enable, direction pin, running flag,
//          and a stop flag with its reason for the request that caused a stop.
//   cfg  - configuration writes (tolerances, encoder present, direction level); always ready.
//          The user writes only while no request is in flight; the block does not enforce it.
// Flow: a request accepted into the input register moves on to the result register
//   once that register is free, and its result is presented from there.
// Throughput: one request per cycle while results are taken; input and result registers
//   form a two-stage pipe, and state is updated in one pass in the second stage.
// Reset: motor stopped, no target armed, step level low, registers at defaults,
//   both pipe stages empty.
// Stall: when res.ready is low the result holds; one more request is taken into
//   the input register, after which req.ready drops until the result is taken.
`include "stepper_step_generator_with_targets_defines.svh"

module stepper_step_generator_with_targets (
	input  logic           clk,
	input  logic           arst_n,
	ssgt_req_if.sink       req,
	ssgt_res_if.source     res,
	ssgt_cfg_if.sink       cfg
);

	ssgt_pkg::cfg_t    cfg_q;
	ssgt_pkg::state_t  state_q;
	ssgt_pkg::state_t  state_nxt;
	ssgt_pkg::item_t   item_s1;
	ssgt_pkg::result_t res_nxt;
	ssgt_pkg::result_t res_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              advance;
	logic              req_take;

	// Pipe control
	assign advance  = ~valid_s2 | res.ready;
	assign req.ready = ~valid_s1 | advance;
	assign req_take = req.valid & req.ready;
	assign cfg.ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.position_tolerance <= ssgt_pkg::POS_TOL_RST;
			cfg_q.backlash_tolerance <= ssgt_pkg::BACKLASH_RST;
			cfg_q.encoder_present    <= ssgt_pkg::ENC_PRESENT_RST;
			cfg_q.direction_level    <= ssgt_pkg::DIR_LEVEL_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				ssgt_pkg::CFG_POS_TOL:     cfg_q.position_tolerance <= cfg.data;
				ssgt_pkg::CFG_BACKLASH:    cfg_q.backlash_tolerance <= cfg.data;
				ssgt_pkg::CFG_ENC_PRESENT: cfg_q.encoder_present    <= cfg.data[0];
				ssgt_pkg::CFG_DIR_LEVEL:   cfg_q.direction_level    <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	// Stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			item_s1.req_type         <= req.req_type;
			item_s1.step_budget      <= req.step_budget;
			item_s1.encoder_goal     <= req.encoder_goal;
			item_s1.encoder_position <= req.encoder_position;
		end
	end

	// Evaluation of the held request against the motor state
	ssgt_eval u_eval (
		.st     (state_q),
		.item   (item_s1),
		.cfg    (cfg_q),
		.st_nxt (state_nxt),
		.res    (res_nxt)
	);

	// Motor state, updated as the request moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// Stage 2: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign res.valid         = valid_s2;
	assign res.step_level    = res_s2.step_level;
	assign res.enable_n      = res_s2.enable_n;
	assign res.direction_out = res_s2.direction_out;
	assign res.is_running    = res_s2.is_running;
	assign res.stop_event    = res_s2.stop_event;
	assign res.stop_reason   = res_s2.stop_reason;

	// Checks
	`SSGT_ASSERT_IMPL(a_one_target, clk, arst_n, 1'b1,
		!(state_q.step_mode_armed && state_q.encoder_mode_armed),
		"step and encoder targets armed together")
	`SSGT_ASSERT_IMPL(a_stop_clears_run, clk, arst_n, valid_s2 && res_s2.stop_event,
		!res_s2.is_running && res_s2.enable_n, "stop result still shows running")
	`SSGT_ASSERT_IMPL(a_reason_needs_stop, clk, arst_n,
		valid_s2 && (res_s2.stop_reason != ssgt_pkg::WHY_COMMANDED),
		res_s2.stop_event, "stop reason without a stop")
	`SSGT_ASSERT_NEXT(a_s1_lands, clk, arst_n, valid_s1 && advance, valid_s2,
		"request in stage 1 lost on its way to the result register")
	`SSGT_ASSERT_NEXT(a_armed_implies_run_or_set, clk, arst_n,
		valid_s1 && advance && state_nxt.encoder_mode_armed && !cfg_q.encoder_present,
		state_q.encoder_mode_armed, "encoder target state not kept")

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the stepper step generator: directed table, then random moves.
// Predicts every result in step with the requests taken; needs ssgt_pkg, the three
// channel interfaces and the top level stepper_step_generator_with_targets.
module tb_top;
	import ssgt_pkg::*;

	localparam int HALF_PERIOD     = 6;
	localparam int CLK_PERIOD      = 2 * HALF_PERIOD;
	localparam int RESET_CYCLES    = 9;
	localparam int SETTLE_CYCLES   = 4;
	localparam int PHASES          = 6;
	localparam int MOVES_PER_PHASE = 258;
	localparam int LONG_HOLD       = 64;
	localparam int WATCHDOG_CYCLES = 600000;

	// Request codes the block does not decode
	localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

	typedef struct {
		item_t   it;
		bit      typed;
		result_t want;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n;

	ssgt_req_if req_ch ();
	ssgt_res_if res_ch ();
	ssgt_cfg_if cfg_ch ();

	stepper_step_generator_with_targets dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	// Shadow of the motor state and the register file
	cfg_t                       shadow_cfg;
	logic                       step_pin;
	logic                       motor_on;
	logic [BUDGET_W-1:0]        steps_to_go;
	logic                       count_armed;
	logic                       goal_armed;
	logic signed [BOUND_W-1:0]  goal_pos;
	logic                       goal_up;
	logic signed [BOUND_W-1:0]  backlash_bound;
	logic                       stop_flag;
	logic [REASON_W-1:0]        stop_why;

	result_t     motor_status_due[$];
	script_row_t script[$];
	int          requests_taken = 0;
	int          status_errors  = 0;
	int          stops_by_reason[4] = '{0, 0, 0, 0};
	int          burst_left     = 0;
	bit          held_once      = 1'b0;
	result_t     status_now;

	// Any stop drops the run flag and both targets; the step level is kept
	function automatic void brake(input logic [REASON_W-1:0] why);
		motor_on    = 1'b0;
		count_armed = 1'b0;
		goal_armed  = 1'b0;
		stop_flag   = 1'b1;
		stop_why    = why;
	endfunction

	// Apply one request to the shadow state and return the pins it leaves
	function automatic result_t advance_motor(input item_t it);
		logic signed [BOUND_W-1:0] cur, goal, diff, tol, slack;
		logic near, hit;
		cur   = BOUND_W'($signed(it.encoder_position));
		goal  = BOUND_W'($signed(it.encoder_goal));
		tol   = BOUND_W'(shadow_cfg.position_tolerance);
		slack = BOUND_W'(shadow_cfg.backlash_tolerance);
		stop_flag = 1'b0;
		stop_why  = WHY_COMMANDED;
		case (it.req_type)
			REQ_TICK: begin
				if (motor_on) begin
					step_pin = !step_pin;
					// targets are only checked on the falling edge
					if (!step_pin) begin
						if (count_armed) begin
							if (steps_to_go != 0)
								steps_to_go = steps_to_go - 1'b1;
							if (steps_to_go == 0)
								brake(WHY_STEPS_DONE);
						end else if (goal_armed && shadow_cfg.encoder_present) begin
							diff = cur - goal_pos;
							if (diff < 0)
								diff = -diff;
							near = diff < tol;
							if (goal_up)
								hit = near || cur >= goal_pos || cur < backlash_bound;
							else
								hit = near || cur <= goal_pos || cur > backlash_bound;
							if (hit)
								brake(near ? WHY_POS_REACHED : WHY_EXCEEDED);
						end
					end
				end
			end
			REQ_START: motor_on = 1'b1;
			REQ_STOP: brake(WHY_COMMANDED);
			REQ_STEP_TARGET: begin
				steps_to_go = it.step_budget;
				count_armed = it.step_budget != 0;
				goal_armed  = 1'b0;
			end
			REQ_ENC_TARGET: begin
				if (shadow_cfg.encoder_present) begin
					diff = goal - cur;
					if (diff < 0)
						diff = -diff;
					goal_pos    = goal;
					count_armed = 1'b0;
					if (diff > tol) begin
						goal_up        = goal > cur;
						backlash_bound = goal_up ? cur - slack : cur + slack;
						goal_armed     = 1'b1;
					end else begin
						goal_armed = 1'b0;
						brake(WHY_POS_REACHED);
					end
				end
			end
			REQ_CLEAR: begin
				count_armed = 1'b0;
				goal_armed  = 1'b0;
			end
			default: ;
		endcase
		return '{step_pin, !motor_on, shadow_cfg.direction_level, motor_on, stop_flag,
			stop_flag ? stop_why : WHY_COMMANDED};
	endfunction

	function automatic item_t make_item(input logic [REQ_W-1:0] code,
		input logic [BUDGET_W-1:0] budget, input logic [POS_W-1:0] goal,
		input logic [POS_W-1:0] pos);
		return '{code, budget, goal, pos};
	endfunction

	// Pins expected at the reset register values
	function automatic result_t pins(input logic step, input logic run, input logic ev,
		input logic [REASON_W-1:0] why);
		return '{step, !run, DIR_LEVEL_RST, run, ev, why};
	endfunction

	function automatic void add_row(input logic [REQ_W-1:0] code,
		input logic [BUDGET_W-1:0] budget, input logic [POS_W-1:0] goal,
		input logic [POS_W-1:0] pos, input bit typed, input result_t want);
		script.push_back('{make_item(code, budget, goal, pos), typed, want});
	endfunction

	// Offer one request, wait for it to be taken, then idle between bursts
	task automatic send_request(input item_t it, input bit typed = 1'b0,
		input result_t want = '0);
		result_t predicted;
		req_ch.valid            <= 1'b1;
		req_ch.req_type         <= it.req_type;
		req_ch.step_budget      <= it.step_budget;
		req_ch.encoder_goal     <= it.encoder_goal;
		req_ch.encoder_position <= it.encoder_position;
		do @(posedge clk); while (!req_ch.ready);
		predicted = advance_motor(it);
		motor_status_due.push_back(typed ? want : predicted);
		requests_taken++;
		if (burst_left == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
				: $urandom_range(0, 12);
		end else begin
			burst_left--;
		end
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (motor_status_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			CFG_POS_TOL:     shadow_cfg.position_tolerance = data;
			CFG_BACKLASH:    shadow_cfg.backlash_tolerance = data;
			CFG_ENC_PRESENT: shadow_cfg.encoder_present    = data[0];
			CFG_DIR_LEVEL:   shadow_cfg.direction_level    = data[0];
			default: ;
		endcase
	endtask

	// Mostly complete moves with random content, the rest loose requests
	task automatic drive_moves(input int count);
		int          stop_at, n, cap;
		logic [31:0] budget;
		longint      base, goal, pos, span, stride, sgn;
		stop_at = requests_taken + count;
		while (requests_taken < stop_at) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					// step budget move, run out or cut short
					case ($urandom_range(0, 5))
						0: budget = '0;
						1: budget = $urandom;
						default: budget = $urandom_range(1, 12);
					endcase
					if ($urandom_range(0, 1))
						send_request(make_item(REQ_START, $urandom, $urandom, $urandom));
					send_request(make_item(REQ_STEP_TARGET, budget, $urandom, $urandom));
					send_request(make_item(REQ_START, $urandom, $urandom, $urandom));
					cap = (budget > 30) ? 40 : 2 * budget + $urandom_range(0, 3);
					n = 0;
					while (motor_on && n < cap) begin
						send_request(make_item(REQ_TICK, $urandom, $urandom, $urandom));
						n++;
					end
					if (motor_on && $urandom_range(0, 1))
						send_request(make_item(REQ_STOP, $urandom, $urandom, $urandom));
				end
				4, 5, 6, 7: begin
					// encoder goal move with a walking, sometimes erratic, position
					if ($urandom_range(0, 7) == 0)
						base = $urandom_range(0, 1) ? 64'sd2147483600 : -64'sd2147483600;
					else
						base = int'($urandom);
					case ($urandom_range(0, 3))
						0: span = $urandom_range(0, 2 * shadow_cfg.position_tolerance + 2);
						1: span = $urandom_range(0, 3000);
						2: span = $urandom_range(0, 300000);
						default: span = $urandom;
					endcase
					sgn  = $urandom_range(0, 1) ? 64'sd1 : -64'sd1;
					goal = base + sgn * span;
					if ($urandom_range(0, 1))
						send_request(make_item(REQ_START, $urandom, $urandom, $urandom));
					send_request(make_item(REQ_ENC_TARGET, $urandom, goal[31:0], base[31:0]));
					send_request(make_item(REQ_START, $urandom, $urandom, base[31:0]));
					pos    = base;
					stride = span / $urandom_range(3, 15) + 1;
					n = 0;
					while (motor_on && n < 60) begin
						case ($urandom_range(0, 9))
							0: pos = pos - sgn * longint'($urandom_range(0, stride));
							1: pos = goal + sgn * longint'($urandom_range(0, stride));
							default: pos = pos + sgn * longint'($urandom_range(0, stride));
						endcase
						send_request(make_item(REQ_TICK, $urandom, $urandom, pos[31:0]));
						n++;
					end
					if (motor_on)
						send_request(make_item($urandom_range(0, 1) ? REQ_STOP : REQ_CLEAR,
							$urandom, $urandom, pos[31:0]));
				end
				default: begin
					repeat ($urandom_range(1, 4))
						send_request(make_item(REQ_W'($urandom_range(REQ_TICK, REQ_SPARE_HI)),
							$urandom, $urandom, $urandom));
				end
			endcase
		end
	endtask

	function automatic void compare_pin(input string what, input logic [1:0] want,
		input logic [1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			status_errors++;
		end
	endfunction

	// Result checker
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (motor_status_due.size() == 0) begin
				$display("%0t: result with none expected, expected nothing, got %p", $time,
					result_t'{res_ch.step_level, res_ch.enable_n, res_ch.direction_out,
					res_ch.is_running, res_ch.stop_event, res_ch.stop_reason});
				status_errors++;
			end else begin
				status_now = motor_status_due.pop_front();
				compare_pin("step_level", 2'(status_now.step_level),
					2'(res_ch.step_level));
				compare_pin("enable_n", 2'(status_now.enable_n), 2'(res_ch.enable_n));
				compare_pin("direction_out", 2'(status_now.direction_out),
					2'(res_ch.direction_out));
				compare_pin("is_running", 2'(status_now.is_running),
					2'(res_ch.is_running));
				compare_pin("stop_event", 2'(status_now.stop_event),
					2'(res_ch.stop_event));
				compare_pin("stop_reason", status_now.stop_reason, res_ch.stop_reason);
			end
			if (res_ch.stop_event === 1'b1)
				stops_by_reason[res_ch.stop_reason]++;
		end
	end

	// Result side stalls in stretches of its own, with the odd long hold-off
	initial begin
		int len, pct;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ((!held_once && requests_taken >= 300) || $urandom_range(0, 40) == 0) begin
				held_once = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				len = $urandom_range(1, 40);
				case ($urandom_range(0, 3))
					0: pct = 0;
					1: pct = 25;
					2: pct = 50;
					default: pct = 80;
				endcase
				repeat (len) begin
					res_ch.ready <= ($urandom_range(0, 99) >= pct);
					@(posedge clk);
				end
			end
		end
	end

	// Watchdog
	initial begin
		#(CLK_PERIOD * WATCHDOG_CYCLES);
		$display("%0t: timeout, %0d results still awaited", $time, motor_status_due.size());
		$display("simulation failed");
		$finish;
	end

	initial begin
		cfg_t settings[PHASES];
		arst_n                  <= 1'b0;
		req_ch.valid            <= 1'b0;
		req_ch.req_type         <= REQ_TICK;
		req_ch.step_budget      <= '0;
		req_ch.encoder_goal     <= '0;
		req_ch.encoder_position <= '0;
		cfg_ch.valid            <= 1'b0;
		cfg_ch.index            <= CFG_POS_TOL;
		cfg_ch.data             <= '0;

		shadow_cfg     = '{POS_TOL_RST, BACKLASH_RST, ENC_PRESENT_RST, DIR_LEVEL_RST};
		step_pin       = 1'b0;
		motor_on       = 1'b0;
		steps_to_go    = '0;
		count_armed    = 1'b0;
		goal_armed     = 1'b0;
		goal_pos       = '0;
		goal_up        = 1'b0;
		backlash_bound = '0;

		// register settings per phase; the first one is the reset state
		settings[0] = '{POS_TOL_RST, BACKLASH_RST, ENC_PRESENT_RST, DIR_LEVEL_RST};
		settings[1] = '{16'd0, 16'd0, 1'b1, 1'b1};
		settings[2] = '{16'hFFFF, 16'hFFFF, 1'b0, 1'b0};
		settings[3] = '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1};
		settings[4] = '{16'($urandom_range(0, 300)), 16'($urandom_range(0, 2000)), 1'b1,
			1'($urandom_range(0, 1))};
		settings[5] = '{16'd3, 16'd20, 1'b1, 1'b0};

		// directed table, reset register values
		add_row(REQ_TICK, 0, 0, 0, 1'b1, pins(1'b0, 1'b0, 1'b0, WHY_COMMANDED));
		add_row(REQ_STOP, 0, 0, 0, 1'b1, pins(1'b0, 1'b0, 1'b1, WHY_COMMANDED));
		add_row(REQ_STEP_TARGET, 0, 0, 0, 1'b1, pins(1'b0, 1'b0, 1'b0, WHY_COMMANDED));
		add_row(REQ_START, 0, 0, 0, 1'b1, pins(1'b0, 1'b1, 1'b0, WHY_COMMANDED));
		add_row(REQ_TICK, 0, 0, 0, 1'b1, pins(1'b1, 1'b1, 1'b0, WHY_COMMANDED));
		add_row(REQ_TICK, 0, 0, 0, 1'b1, pins(1'b0, 1'b1, 1'b0, WHY_COMMANDED));
		add_row(REQ_STEP_TARGET, 2, 0, 0, 1'b1, pins(1'b0, 1'b1, 1'b0, WHY_COMMANDED));
		add_row(REQ_TICK, 0, 0, 0, 1'b0, '0);
		add_row(REQ_TICK, 0, 0, 0, 1'b0, '0);
		add_row(REQ_TICK, 0, 0, 0, 1'b0, '0);
		add_row(REQ_TICK, 0, 0, 0, 1'b1, pins(1'b0, 1'b0, 1'b1, WHY_STEPS_DONE));
		// goal exactly at tolerance counts as reached when it is set
		add_row(REQ_ENC_TARGET, 0, 1000, 990, 1'b1, pins(1'b0, 1'b0, 1'b1, WHY_POS_REACHED));
		// wrong-way motion past the backlash bound
		add_row(REQ_START, 0, 0, 0, 1'b0, '0);
		add_row(REQ_ENC_TARGET, 0, 5000, 0, 1'b0, '0);
		add_row(REQ_TICK, 0, 0, -101, 1'b0, '0);
		add_row(REQ_TICK, 0, 0, -101, 1'b1, pins(1'b0, 1'b0, 1'b1, WHY_EXCEEDED));
		// full-range goal, no wrap in the difference
		add_row(REQ_START, 0, 0, 0, 1'b0, '0);
		add_row(REQ_ENC_TARGET, 0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0);
		add_row(REQ_TICK, 0, 0, 32'h7FFF_FFFF, 1'b0, '0);
		add_row(REQ_TICK, 0, 0, 32'h8000_0009, 1'b1, pins(1'b0, 1'b0, 1'b1, WHY_POS_REACHED));
		add_row(REQ_STEP_TARGET, 32'hFFFF_FFFF, 0, 0, 1'b0, '0);
		add_row(REQ_START, 0, 0, 0, 1'b0, '0);
		add_row(REQ_TICK, 0, 0, 0, 1'b0, '0);
		add_row(REQ_TICK, 0, 0, 0, 1'b0, '0);
		add_row(REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0);
		add_row(REQ_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0);
		add_row(REQ_SPARE_LO, 0, 0, 0, 1'b0, '0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			send_request(script[i].it, script[i].typed, script[i].want);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph != 0) begin
				// leave a far goal armed so the new setting meets it mid-move
				send_request(make_item(REQ_START, $urandom, $urandom, 0));
				send_request(make_item(REQ_ENC_TARGET, $urandom, 1000000, 0));
				wait_drained();
				write_reg(CFG_POS_TOL, settings[ph].position_tolerance);
				write_reg(CFG_BACKLASH, settings[ph].backlash_tolerance);
				write_reg(CFG_ENC_PRESENT, {15'd0, settings[ph].encoder_present});
				write_reg(CFG_DIR_LEVEL, {15'd0, settings[ph].direction_level});
				cfg_ch.valid <= 1'b0;
			end
			drive_moves(MOVES_PER_PHASE);
		end

		wait_drained();
		$display("Ran %0d requests over %0d register settings; long result hold-off %s.",
			requests_taken, PHASES, held_once ? "seen" : "not seen");
		$display("Stops: commanded %0d, budget done %0d, goal reached %0d, overrun %0d.",
			stops_by_reason[WHY_COMMANDED], stops_by_reason[WHY_STEPS_DONE],
			stops_by_reason[WHY_POS_REACHED], stops_by_reason[WHY_EXCEEDED]);
		if (status_errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
